/* rtl/aapm_pkg.sv */
// Package: widths, codes, symbol constants and ramp functions for the ASCII pixel mapper.
`default_nettype none

package aapm_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   localparam int PIXEL_W    = 8;
   localparam int SYMBOL_W   = 7;
   localparam int COLUMN_W   = 10;
   localparam int ROW_W      = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam int STYLE_W    = 3;
   localparam int FWIDTH_W   = 11;
   localparam int FHEIGHT_W  = 13;

   localparam int FRAME_WIDTH_RESET    = 1024;
   localparam int FRAME_HEIGHT_RESET   = 4096;
   localparam int EDGE_THRESHOLD_RESET = 50;

   // x / 17 == (x * 241) >> 12 for every 8-bit x
   localparam int RECIP_17    = 241;
   localparam int RECIP_SHIFT = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STYLE_MODE     = 2'd0,
      CSR_FRAME_WIDTH    = 2'd1,
      CSR_FRAME_HEIGHT   = 2'd2,
      CSR_EDGE_THRESHOLD = 2'd3
   } csr_index_type;

   typedef enum logic [STYLE_W-1:0] {
      STYLE_CLASSIC    = 3'd0,
      STYLE_INVERSE    = 3'd1,
      STYLE_HORIZONTAL = 3'd2,
      STYLE_VERTICAL   = 3'd3,
      STYLE_GRADIENT   = 3'd4,
      STYLE_COMPARE    = 3'd5
   } style_type;

   localparam logic [SYMBOL_W-1:0] SYM_SPACE   = 7'h20;
   localparam logic [SYMBOL_W-1:0] SYM_PERCENT = 7'h25;
   localparam logic [SYMBOL_W-1:0] SYM_AMP     = 7'h26;
   localparam logic [SYMBOL_W-1:0] SYM_STAR    = 7'h2A;
   localparam logic [SYMBOL_W-1:0] SYM_PLUS    = 7'h2B;
   localparam logic [SYMBOL_W-1:0] SYM_MINUS   = 7'h2D;
   localparam logic [SYMBOL_W-1:0] SYM_DOT     = 7'h2E;
   localparam logic [SYMBOL_W-1:0] SYM_ZERO    = 7'h30;
   localparam logic [SYMBOL_W-1:0] SYM_ONE     = 7'h31;
   localparam logic [SYMBOL_W-1:0] SYM_TWO     = 7'h32;
   localparam logic [SYMBOL_W-1:0] SYM_THREE   = 7'h33;
   localparam logic [SYMBOL_W-1:0] SYM_FOUR    = 7'h34;
   localparam logic [SYMBOL_W-1:0] SYM_LESS    = 7'h3C;
   localparam logic [SYMBOL_W-1:0] SYM_GREATER = 7'h3E;
   localparam logic [SYMBOL_W-1:0] SYM_AT      = 7'h40;
   localparam logic [SYMBOL_W-1:0] SYM_A       = 7'h41;
   localparam logic [SYMBOL_W-1:0] SYM_H       = 7'h48;
   localparam logic [SYMBOL_W-1:0] SYM_O       = 7'h4F;
   localparam logic [SYMBOL_W-1:0] SYM_T       = 7'h54;
   localparam logic [SYMBOL_W-1:0] SYM_W       = 7'h57;
   localparam logic [SYMBOL_W-1:0] SYM_X       = 7'h58;
   localparam logic [SYMBOL_W-1:0] SYM_CARET   = 7'h5E;
   localparam logic [SYMBOL_W-1:0] SYM_PIPE    = 7'h7C;

   // operands of one result as loaded into a cell
   typedef struct packed {
      logic [PIXEL_W-1:0]  cur;
      logic [PIXEL_W-1:0]  right;
      logic [PIXEL_W-1:0]  under;
      logic                lastc;
      logic                lastr;
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row;
      logic                last;
      logic                done;
   } cell_ops_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row;
      logic                last;
      logic                done;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } slot_type;

   function automatic logic [3:0] div17(input logic [PIXEL_W-1:0] x);
      logic [15:0] prod;
      prod = 16'(x) * 16'(RECIP_17);
      return prod[15:RECIP_SHIFT];
   endfunction

   function automatic logic [SYMBOL_W-1:0] ramp_classic(input logic [3:0] q);
      logic [SYMBOL_W-1:0] s;
      case (q)
         4'd0:    s = SYM_AT;
         4'd1:    s = SYM_AMP;
         4'd2:    s = SYM_PERCENT;
         4'd3:    s = SYM_W;
         4'd4:    s = SYM_X;
         4'd5:    s = SYM_A;
         4'd6:    s = SYM_H;
         4'd7:    s = SYM_O;
         4'd8:    s = SYM_T;
         4'd9:    s = SYM_STAR;
         4'd10:   s = SYM_CARET;
         4'd11:   s = SYM_PLUS;
         4'd12:   s = SYM_MINUS;
         4'd13:   s = SYM_DOT;
         default: s = SYM_SPACE;
      endcase
      return s;
   endfunction

   function automatic logic [SYMBOL_W-1:0] ramp_inverse(input logic [3:0] q);
      logic [SYMBOL_W-1:0] s;
      case (q)
         4'd0:    s = SYM_SPACE;
         4'd1:    s = SYM_DOT;
         4'd2:    s = SYM_MINUS;
         4'd3:    s = SYM_PLUS;
         4'd4:    s = SYM_CARET;
         4'd5:    s = SYM_STAR;
         4'd6:    s = SYM_T;
         4'd7:    s = SYM_O;
         4'd8:    s = SYM_H;
         4'd9:    s = SYM_A;
         4'd10:   s = SYM_X;
         4'd11:   s = SYM_W;
         4'd12:   s = SYM_PERCENT;
         4'd13:   s = SYM_AMP;
         default: s = SYM_AT;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

/* rtl/aapm_if.sv */
// Interfaces: pixel request, symbol response and register write channels.
`default_nettype none

interface aapm_req_if;
   logic                         valid;
   logic                         ready;
   logic [aapm_pkg::PIXEL_W-1:0] pixel_value;
   modport source (output valid, output pixel_value, input ready);
   modport sink (input valid, input pixel_value, output ready);
endinterface

interface aapm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [aapm_pkg::SYMBOL_W-1:0] symbol_code;
   logic [aapm_pkg::COLUMN_W-1:0] pixel_column;
   logic [aapm_pkg::ROW_W-1:0]    pixel_row;
   logic                          last_of_run;
   logic                          frame_done;
   modport source (output valid, output symbol_code, output pixel_column, output pixel_row,
                   output last_of_run, output frame_done, input ready);
   modport sink (input valid, input symbol_code, input pixel_column, input pixel_row,
                 input last_of_run, input frame_done, output ready);
endinterface

interface aapm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [aapm_pkg::CSR_IDX_W-1:0]  index;
   logic [aapm_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/aapm_ram.sv */
// Generic RAM: one write port, two registered read ports, read-before-write.
`default_nettype none

module aapm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

/* rtl/aapm_cell.sv */
// Output cell: picks the symbol on load, shifts in its neighbor's result on shift, else holds.
`default_nettype none

module aapm_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic                            shift,
   input  logic                            load_valid,
   input  aapm_pkg::cell_ops_type          load_ops,
   input  logic [aapm_pkg::STYLE_W-1:0]    style,
   input  logic [aapm_pkg::PIXEL_W-1:0]    threshold,
   input  aapm_pkg::slot_type              next_slot,
   output aapm_pkg::slot_type              slot
);
   import aapm_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   rsp_item_type        item_ff;
   rsp_item_type        item_in;
   logic [PIXEL_W-1:0]  dr;
   logic [PIXEL_W-1:0]  du;
   logic [SYMBOL_W-1:0] symbol;

   assign dr = (load_ops.cur > load_ops.right) ? load_ops.cur - load_ops.right
                                               : load_ops.right - load_ops.cur;
   assign du = (load_ops.cur > load_ops.under) ? load_ops.cur - load_ops.under
                                               : load_ops.under - load_ops.cur;

   always_comb begin
      unique case (style)
         STYLE_INVERSE: symbol = ramp_inverse(div17(load_ops.cur));
         STYLE_HORIZONTAL: begin
            symbol = (!load_ops.lastc && dr > threshold) ? SYM_PIPE : SYM_ZERO;
         end
         STYLE_VERTICAL: begin
            symbol = (!load_ops.lastr && du > threshold) ? SYM_MINUS : SYM_SPACE;
         end
         STYLE_GRADIENT: begin
            if (load_ops.lastc && load_ops.lastr) begin
               symbol = SYM_ONE;
            end else if (load_ops.lastc) begin
               symbol = (du > threshold) ? SYM_MINUS : SYM_TWO;
            end else if (load_ops.lastr) begin
               symbol = (dr > threshold) ? SYM_PIPE : SYM_THREE;
            end else if (dr < threshold && du > threshold) begin
               symbol = SYM_MINUS;
            end else if (dr > threshold && du < threshold) begin
               symbol = SYM_PIPE;
            end else if (dr > threshold && du > threshold) begin
               symbol = SYM_PLUS;
            end else begin
               symbol = SYM_FOUR;
            end
         end
         STYLE_COMPARE: begin
            if (load_ops.lastc) begin
               symbol = SYM_SPACE;
            end else begin
               symbol = (load_ops.cur > load_ops.right) ? SYM_GREATER : SYM_LESS;
            end
         end
         default: symbol = ramp_classic(div17(load_ops.cur));
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in       = load_valid;
         item_in.symbol = symbol;
         item_in.column = load_ops.column;
         item_in.row    = load_ops.row;
         item_in.last   = load_ops.last;
         item_in.done   = load_ops.done;
      end else if (shift) begin
         valid_in = next_slot.valid;
         item_in  = next_slot.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign slot.valid = valid_ff;
   assign slot.item  = item_ff;

endmodule

`default_nettype wire

/* rtl/ascii_art_pixel_mapper_core.sv */
// Top level: ASCII art pixel mapper, gray pixels in raster order to one symbol each.
// Channels: req_ch takes one 8-bit pixel per item, rsp_ch gives one symbol item with
// its column, row, last_of_run and frame_done; csr_ch writes style_mode (0),
// frame_width (1), frame_height (2) and edge_threshold (3), always ready.
// A row buffer RAM holds the previous row. The result for (c,r-1) leaves with the
// item for (c,r); in the last row (c-1,r) follows, and the last pixel adds its own.
// An item passes the input stage and then a result cell before its first result is
// shown; a full cell chain holds it in the input stage.
// Throughput: 1 item per cycle while each item gives at most one result and rsp_ch
// does not stall; in the last row items can give two results and the last pixel of a
// frame three, which the output port gives one at a time. A chain of three result
// cells feeds the port and takes a new group once it is empty or its last one leaves.
// Reset: counters, left pixel and registers return to defaults; the row buffer is not
// cleared; no clearing pass is needed (row 0 writes each entry in the frame width first).
// Stall: with rsp_ch held, items without results still pass; one more item with results
// is absorbed in the input stage, then req_ch.ready drops until the cells can take them.
`default_nettype none

module ascii_art_pixel_mapper_core #(
   parameter int MAX_WIDTH  = aapm_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = aapm_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   aapm_req_if.sink    req_ch,
   aapm_rsp_if.source  rsp_ch,
   aapm_csr_if.sink    csr_ch
);
   import aapm_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WM1_RESET =
      ((FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET) - 1;
   localparam int HM1_RESET =
      ((FRAME_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RESET) - 1;
   localparam int NCELL = 3;

   // registers
   logic [STYLE_W-1:0]   style_ff, style_in;
   logic [PIXEL_W-1:0]   thresh_ff, thresh_in;
   logic [CW-1:0]        wm1_ff, wm1_in;
   logic [RW-1:0]        hm1_ff, hm1_in;
   logic [FWIDTH_W-1:0]  fw_wr;
   logic [FHEIGHT_W-1:0] fh_wr;
   logic [CW-1:0]        wm1_cfg;
   logic [RW-1:0]        hm1_cfg;

   // position and input stage
   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [PIXEL_W-1:0]   left_ff, left_in;
   logic [CW-1:0]        c_cur;
   logic [RW-1:0]        r_cur;
   logic                 lastc_cur;
   logic                 lastr_cur;
   logic                 accept;

   logic                 s1_valid_ff, s1_valid_in;
   logic [PIXEL_W-1:0]   s1_pix_ff;
   logic [PIXEL_W-1:0]   s1_left_ff;
   logic [CW-1:0]        s1_c_ff;
   logic [RW-1:0]        s1_r_ff;
   logic                 s1_lastc_ff;
   logic                 s1_has_a_ff;
   logic                 s1_has_b_ff;
   logic                 s1_has_c_ff;
   logic                 s1_any;
   logic                 s1_retire;

   logic [PIXEL_W-1:0]   rd_a;
   logic [PIXEL_W-1:0]   rd_b;

   // cells
   cell_ops_type         op_a, op_b, op_c;
   cell_ops_type         load_ops [NCELL];
   logic [NCELL-1:0]     load_valid;
   slot_type             cell_slot [NCELL];
   logic                 load;
   logic                 shift;
   logic                 chain_free;

   // register writes
   assign csr_ch.ready = 1'b1;
   assign fw_wr = csr_ch.data[FWIDTH_W-1:0];
   assign fh_wr = csr_ch.data[FHEIGHT_W-1:0];

   always_comb begin
      if (fw_wr == '0) begin
         wm1_cfg = '0;
      end else if (32'(fw_wr) > 32'(MAX_WIDTH)) begin
         wm1_cfg = CW'(MAX_WIDTH - 1);
      end else begin
         wm1_cfg = CW'(32'(fw_wr) - 32'd1);
      end
      if (fh_wr == '0) begin
         hm1_cfg = '0;
      end else if (32'(fh_wr) > 32'(MAX_HEIGHT)) begin
         hm1_cfg = RW'(MAX_HEIGHT - 1);
      end else begin
         hm1_cfg = RW'(32'(fh_wr) - 32'd1);
      end
   end

   always_comb begin
      style_in  = style_ff;
      thresh_in = thresh_ff;
      wm1_in    = wm1_ff;
      hm1_in    = hm1_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_STYLE_MODE:     style_in  = csr_ch.data[STYLE_W-1:0];
            CSR_FRAME_WIDTH:    wm1_in    = wm1_cfg;
            CSR_FRAME_HEIGHT:   hm1_in    = hm1_cfg;
            CSR_EDGE_THRESHOLD: thresh_in = csr_ch.data[PIXEL_W-1:0];
            default:            style_in  = style_ff;
         endcase
      end
   end

   // position of the incoming pixel, clamped to a shrunk frame
   assign c_cur     = (col_ff > wm1_ff) ? wm1_ff : col_ff;
   assign r_cur     = (row_ff > hm1_ff) ? hm1_ff : row_ff;
   assign lastc_cur = (c_cur == wm1_ff);
   assign lastr_cur = (r_cur == hm1_ff);
   assign accept    = req_ch.valid && req_ch.ready;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (accept) begin
         left_in = req_ch.pixel_value;
         if (lastc_cur) begin
            col_in = '0;
            row_in = lastr_cur ? '0 : RW'(r_cur + 1'b1);
         end else begin
            col_in = CW'(c_cur + 1'b1);
            row_in = r_cur;
         end
      end
   end

   aapm_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_buf (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (c_cur),
      .wr_data   (req_ch.pixel_value),
      .rd_en     (accept),
      .rd_addr_a (c_cur),
      .rd_addr_b (CW'(c_cur + 1'b1)),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // input stage holds the item while the row buffer read completes and until the cells take its results
   assign s1_any    = s1_has_a_ff || s1_has_b_ff || s1_has_c_ff;
   assign shift     = rsp_ch.valid && rsp_ch.ready;
   assign chain_free = !cell_slot[0].valid || (shift && !cell_slot[1].valid);
   assign load      = s1_valid_ff && s1_any && chain_free;
   assign s1_retire = s1_valid_ff && (!s1_any || chain_free);
   assign req_ch.ready = !s1_valid_ff || s1_retire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_retire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff    <= STYLE_CLASSIC;
         thresh_ff   <= PIXEL_W'(EDGE_THRESHOLD_RESET);
         wm1_ff      <= CW'(WM1_RESET);
         hm1_ff      <= RW'(HM1_RESET);
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         style_ff    <= style_in;
         thresh_ff   <= thresh_in;
         wm1_ff      <= wm1_in;
         hm1_ff      <= hm1_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         left_ff     <= left_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_pix_ff   <= req_ch.pixel_value;
         s1_left_ff  <= left_ff;
         s1_c_ff     <= c_cur;
         s1_r_ff     <= r_cur;
         s1_lastc_ff <= lastc_cur;
         s1_has_a_ff <= (r_cur != '0);
         s1_has_b_ff <= lastr_cur && (c_cur != '0);
         s1_has_c_ff <= lastr_cur && lastc_cur;
      end
   end

   // results of one item: pixel above, left neighbor in last row, last pixel
   always_comb begin
      op_a.cur    = rd_a;
      op_a.right  = s1_lastc_ff ? '0 : rd_b;
      op_a.under  = s1_pix_ff;
      op_a.lastc  = s1_lastc_ff;
      op_a.lastr  = 1'b0;
      op_a.column = COLUMN_W'(s1_c_ff);
      op_a.row    = ROW_W'(RW'(s1_r_ff - 1'b1));
      op_a.last   = !(s1_has_b_ff || s1_has_c_ff);
      op_a.done   = 1'b0;

      op_b.cur    = s1_left_ff;
      op_b.right  = s1_pix_ff;
      op_b.under  = '0;
      op_b.lastc  = 1'b0;
      op_b.lastr  = 1'b1;
      op_b.column = COLUMN_W'(CW'(s1_c_ff - 1'b1));
      op_b.row    = ROW_W'(s1_r_ff);
      op_b.last   = !s1_has_c_ff;
      op_b.done   = 1'b0;

      op_c.cur    = s1_pix_ff;
      op_c.right  = '0;
      op_c.under  = '0;
      op_c.lastc  = 1'b1;
      op_c.lastr  = 1'b1;
      op_c.column = COLUMN_W'(s1_c_ff);
      op_c.row    = ROW_W'(s1_r_ff);
      op_c.last   = 1'b1;
      op_c.done   = 1'b1;

      load_ops[0] = s1_has_a_ff ? op_a : (s1_has_b_ff ? op_b : op_c);
      load_ops[1] = (s1_has_a_ff && s1_has_b_ff) ? op_b : op_c;
      load_ops[2] = op_c;

      load_valid[0] = s1_any;
      load_valid[1] = (s1_has_a_ff && s1_has_b_ff) || (s1_has_a_ff && s1_has_c_ff)
                      || (s1_has_b_ff && s1_has_c_ff);
      load_valid[2] = s1_has_a_ff && s1_has_b_ff && s1_has_c_ff;
   end

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      slot_type next_slot;
      if (i < NCELL - 1) begin : g_mid
         assign next_slot = cell_slot[i+1];
      end else begin : g_end
         assign next_slot = '0;
      end
      aapm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (load),
         .shift      (shift),
         .load_valid (load_valid[i]),
         .load_ops   (load_ops[i]),
         .style      (style_ff),
         .threshold  (thresh_ff),
         .next_slot  (next_slot),
         .slot       (cell_slot[i])
      );
   end

   assign rsp_ch.valid        = cell_slot[0].valid;
   assign rsp_ch.symbol_code  = cell_slot[0].item.symbol;
   assign rsp_ch.pixel_column = cell_slot[0].item.column;
   assign rsp_ch.pixel_row    = cell_slot[0].item.row;
   assign rsp_ch.last_of_run  = cell_slot[0].item.last;
   assign rsp_ch.frame_done   = cell_slot[0].item.done;

endmodule

`default_nettype wire

/* rtl/aapm_checker.sv */
// Checker on the top-level ports of the ASCII pixel mapper, bound to the top level.
`default_nettype none

module aapm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [aapm_pkg::SYMBOL_W-1:0] rsp_symbol_code,
   input wire logic [aapm_pkg::COLUMN_W-1:0] rsp_pixel_column,
   input wire logic [aapm_pkg::ROW_W-1:0]    rsp_pixel_row,
   input wire logic                          rsp_last_of_run,
   input wire logic                          rsp_frame_done
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol_code)
         && $stable(rsp_pixel_column) && $stable(rsp_pixel_row)
         && $stable(rsp_last_of_run) && $stable(rsp_frame_done))
      else $error("stalled result changed");

   // the end of a frame always closes the run of its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last_of_run)
      else $error("frame_done without last_of_run");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   assert property (@(posedge clock) reset |=> req_ready)
      else $error("input not ready right after reset");

   // input only stalls behind a pending result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

endmodule

bind ascii_art_pixel_mapper_core aapm_checker u_aapm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_symbol_code  (rsp_ch.symbol_code),
   .rsp_pixel_column (rsp_ch.pixel_column),
   .rsp_pixel_row    (rsp_ch.pixel_row),
   .rsp_last_of_run  (rsp_ch.last_of_run),
   .rsp_frame_done   (rsp_ch.frame_done)
);

`default_nettype wire
